// File: sv/mzrt_pkg.sv
`timescale 1ns / 1ps

package mzrt_pkg;

  localparam int unsigned NumZones    = 3;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 16;
  localparam int unsigned DelayRegBits = 16;

  localparam logic [DelayRegBits-1:0] DelayReset    = 16'd30;
  localparam logic [NumZones-1:0]     ForceReset    = 3'b000;
  localparam logic [NumZones-1:0]     SensorEnReset = 3'b111;

  typedef enum logic [1:0] {
    OP_SENSOR  = 2'd0,
    OP_TICK    = 2'd1,
    OP_IRQ_ACK = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_ZONE1_DELAY = 3'd0,
    REG_ZONE2_DELAY = 3'd1,
    REG_ZONE3_DELAY = 3'd2,
    REG_FORCE_ON    = 3'd3,
    REG_SENSOR_EN   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    op_e                 opcode;
    logic [NumZones-1:0] sensor_levels;
  } in_t;

  typedef struct packed {
    logic [NumZones-1:0] relay_pins;
    logic [NumZones-1:0] zone_flags;
    logic                irq;
  } out_t;

  typedef struct packed {
    logic [NumZones-1:0][DelayRegBits-1:0] delay;
    logic [NumZones-1:0]                   force_mask;
    logic [NumZones-1:0]                   sensor_en;
  } cfg_t;

endpackage

// File: sv/motion_zone_relay_timer_core.sv
`timescale 1ns / 1ps
// A result beat passes through the input register and then the result register
// before it is presented; a full result register can hold it in between.
// Throughput: one beat per cycle while the output is accepted; the zone update is a single pass of logic.
// Reset (rst_ni low, asynchronous): relays, flags, pins and interrupt clear,
// counters and delays load 30 ticks, force mask clears, sensors enabled.
module motion_zone_relay_timer_core #(
  parameter int unsigned DELAY_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  mzrt_pkg::in_t                    in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output mzrt_pkg::out_t                   out_data_o,
  input  logic                             cfg_we_i,
  input  logic [mzrt_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [mzrt_pkg::CfgDataBits-1:0] cfg_wdata_i
);
  import mzrt_pkg::*;

  logic in_valid_q, in_valid_d;
  in_t  in_q;
  logic out_valid_q, out_valid_d;
  out_t out_q;
  out_t result;
  cfg_t cfg;
  logic advance;

  // A held beat moves on whenever the result register is free or drains now.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d  = in_valid_q;
    out_valid_d = out_valid_q;
    if (in_ready_o) begin
      in_valid_d = in_valid_i;
    end
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  mzrt_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mzrt_zone_ctrl #(
    .DelayBits (DELAY_BITS)
  ) u_zone (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: sv/mzrt_cfg_regs.sv
`timescale 1ns / 1ps

module mzrt_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mzrt_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [mzrt_pkg::CfgDataBits-1:0]    cfg_wdata_i,
  output mzrt_pkg::cfg_t                      cfg_o
);
  import mzrt_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ZONE1_DELAY: cfg_d.delay[0] = DelayRegBits'(cfg_wdata_i);
        REG_ZONE2_DELAY: cfg_d.delay[1] = DelayRegBits'(cfg_wdata_i);
        REG_ZONE3_DELAY: cfg_d.delay[2] = DelayRegBits'(cfg_wdata_i);
        REG_FORCE_ON:    cfg_d.force_mask = cfg_wdata_i[NumZones-1:0];
        REG_SENSOR_EN:   cfg_d.sensor_en = cfg_wdata_i[NumZones-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delay      <= {NumZones{DelayReset}};
      cfg_q.force_mask <= ForceReset;
      cfg_q.sensor_en  <= SensorEnReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/mzrt_zone_ctrl.sv
`timescale 1ns / 1ps

module mzrt_zone_ctrl #(
  parameter int unsigned DelayBits = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  mzrt_pkg::in_t  item_i,
  input  mzrt_pkg::cfg_t cfg_i,
  output mzrt_pkg::out_t result_o
);
  import mzrt_pkg::*;

  // The status flag of a zone is its relay register; the relay pins are a
  // separate register that copies it only on a tick.
  logic [NumZones-1:0]                relay_q, relay_d;
  logic [NumZones-1:0]                pin_q, pin_d;
  logic                               irq_q, irq_d;
  logic [NumZones-1:0][DelayBits-1:0] count_q, count_d;
  logic [NumZones-1:0][DelayBits-1:0] reload;
  logic [NumZones-1:0][DelayBits-1:0] count_dec;
  logic [NumZones-1:0]                trigger;

  always_comb begin
    for (int z = 0; z < NumZones; z++) begin
      reload[z]    = DelayBits'(cfg_i.delay[z]);
      count_dec[z] = count_q[z] - DelayBits'(1);
    end
    trigger = (~item_i.sensor_levels & cfg_i.sensor_en) | cfg_i.force_mask;
  end

  always_comb begin
    relay_d = relay_q;
    pin_d   = pin_q;
    irq_d   = irq_q;
    count_d = count_q;
    if (step_i) begin
      case (item_i.opcode)
        OP_SENSOR: begin
          for (int z = 0; z < NumZones; z++) begin
            if (trigger[z]) begin
              relay_d[z] = 1'b1;
              count_d[z] = reload[z];
            end
          end
          irq_d = irq_q | (|relay_d);
        end
        OP_TICK: begin
          for (int z = 0; z < NumZones; z++) begin
            if (!cfg_i.force_mask[z] && relay_q[z]) begin
              if (count_dec[z] == '0) begin
                relay_d[z] = 1'b0;
                count_d[z] = reload[z];
              end else begin
                count_d[z] = count_dec[z];
              end
            end
          end
          pin_d = relay_d;
        end
        OP_IRQ_ACK: begin
          irq_d = 1'b0;
        end
        default: begin
          irq_d = irq_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relay_q <= '0;
      pin_q   <= '0;
      irq_q   <= 1'b0;
      count_q <= {NumZones{DelayBits'(DelayReset)}};
    end else begin
      relay_q <= relay_d;
      pin_q   <= pin_d;
      irq_q   <= irq_d;
      count_q <= count_d;
    end
  end

  // The result reflects the state after this beat has been applied.
  assign result_o.relay_pins = pin_d;
  assign result_o.zone_flags = relay_d;
  assign result_o.irq        = irq_d;

  a_pins_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(step_i && item_i.opcode == OP_TICK) |=> $stable(pin_q))
    else $error("relay pins changed without a tick");

  a_irq_rises_on_sensor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(step_i && item_i.opcode == OP_SENSOR) |=> !$rose(irq_q))
    else $error("interrupt raised outside a sensor event");

  a_trigger_sets_irq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && item_i.opcode == OP_SENSOR && trigger != '0) |=> irq_q && relay_q != '0)
    else $error("triggered zone did not raise relay and interrupt");

  a_forced_zone_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && item_i.opcode == OP_TICK)
    |=> ((relay_q & $past(cfg_i.force_mask)) == ($past(relay_q) & $past(cfg_i.force_mask))))
    else $error("forced zone changed on a tick");

endmodule
